### sv/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("%m failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

### sv/fp64sc_pkg.sv
// constants shared by the double scaling pipeline
package fp64sc_pkg;
    localparam logic [63:0] INF_BITS   = 64'h7ff0_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT  = 64'h0008_0000_0000_0000;
    localparam logic [63:0] SIGN_MASK  = 64'h8000_0000_0000_0000;
    localparam int          EXP_MAX_FIN = 2046;
    localparam int unsigned SIG_W = 53;
    // subnormal normalization: exponent carried wide enough to never wrap
    localparam int unsigned EXP_W = 34;

    // special case codes decided in stage one
    typedef enum logic [1:0] {
        K_PASS,
        K_QUIET,
        K_NUM
    } t_kind;
endpackage

### sv/fp64_scale_by_power_of_two.sv
// fp64_scale_by_power_of_two: binary64 x * 2^n, round to nearest even
// Usage:
//   input channel i_valid/o_ready carries i_x_bits and i_shift_count (signed)
//   output channel o_valid/i_ready carries o_result_bits and four flags
//   (invalid, overflow, underflow, inexact), one result beat per input beat.
// Pipeline: four register stages; o_valid is the valid bit of the fourth.
//   stage 1 classifies the operand and finds the leading one of a subnormal
//   stage 2 normalizes the significand and adds the count to the exponent
//   stage 3 decides overflow / normal / tiny and shifts the significand right
//   stage 4 rounds to nearest even and forms the result
// Throughput: one beat per cycle while the output beat is taken.
// Stall: a full stage holds while the stage after it holds; a bubble
//   in a stage is filled, so o_ready is low only when every stage is full and
//   i_ready is low.
// Reset: synchronous, active low; clears all valid bits, no beat is in flight.
module fp64_scale_by_power_of_two
    import fp64sc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_x_bits,
    input  logic signed [31:0] i_shift_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_bits,
    output logic        o_flag_invalid,
    output logic        o_flag_overflow,
    output logic        o_flag_underflow,
    output logic        o_flag_inexact
);
`include "assert_macros.svh"

    logic [3:0] r_vld;
    logic [3:0] en;

    // a stage advances when it is empty or the one after it advances
    assign en[3] = !r_vld[3] || i_ready;
    assign en[2] = !r_vld[2] || en[3];
    assign en[1] = !r_vld[1] || en[2];
    assign en[0] = !r_vld[0] || en[1];
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
        end
    end

    // ---------------- stage 1: classify, leading zero count
    logic [62:0] mag;
    logic [5:0]  lz;
    t_kind       n1_kind;
    assign mag = i_x_bits[62:0];

    always_comb begin
        lz = '0;
        for (int i = 0; i <= 51; i++) begin
            if (mag[i]) lz = 6'(52 - i);
        end
    end

    always_comb begin
        if ({1'b0, mag} > INF_BITS) begin
            n1_kind = mag[51] ? K_PASS : K_QUIET;
        end else if ({1'b0, mag} == INF_BITS || mag == '0 || i_shift_count == '0) begin
            n1_kind = K_PASS;
        end else begin
            n1_kind = K_NUM;
        end
    end

    t_kind       r1_kind;
    logic [63:0] r1_x;
    logic [5:0]  r1_lz;
    logic signed [31:0] r1_cnt;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_kind <= n1_kind;
            r1_x    <= i_x_bits;
            r1_lz   <= lz;
            r1_cnt  <= i_shift_count;
        end
    end

    // ---------------- stage 2: normalize, add count
    logic                    sub1;
    logic [SIG_W-1:0]        n2_sig;
    logic signed [EXP_W-1:0] n2_exp;
    assign sub1 = (r1_x[62:52] == '0);

    always_comb begin
        if (sub1) begin
            n2_sig = {1'b0, r1_x[51:0]} << r1_lz;
            n2_exp = EXP_W'(signed'(r1_cnt)) + EXP_W'(1) - EXP_W'(r1_lz);
        end else begin
            n2_sig = {1'b1, r1_x[51:0]};
            n2_exp = EXP_W'(signed'(r1_cnt)) + EXP_W'(r1_x[62:52]);
        end
    end

    t_kind                   r2_kind;
    logic [63:0]             r2_x;
    logic [SIG_W-1:0]        r2_sig;
    logic signed [EXP_W-1:0] r2_exp;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_kind <= r1_kind;
            r2_x    <= r1_x;
            r2_sig  <= n2_sig;
            r2_exp  <= n2_exp;
        end
    end

    // ---------------- stage 3: range check and denormalizing shift
    logic                    ovf3, nrm3, far3;
    logic signed [EXP_W-1:0] sh_w;
    logic [5:0]              sh;
    logic [SIG_W-1:0]        q3;
    logic [SIG_W-1:0]        rem3;
    logic [SIG_W-1:0]        half3;

    assign ovf3 = r2_exp > EXP_W'(EXP_MAX_FIN);
    assign nrm3 = r2_exp >= EXP_W'(1);
    assign sh_w = EXP_W'(1) - r2_exp;
    assign far3 = sh_w > EXP_W'(54);
    assign sh   = sh_w[5:0];

    always_comb begin
        q3    = r2_sig >> sh;
        half3 = SIG_W'(1) << (sh - 6'd1);
        rem3  = r2_sig & ((SIG_W'(1) << sh) - SIG_W'(1));
        if (sh == 6'd54) begin
            // everything shifts out; the top bit of the significand falls below half
            half3 = '0;
            rem3  = r2_sig;
        end
    end

    t_kind            r3_kind;
    logic [63:0]      r3_x;
    logic             r3_ovf, r3_nrm, r3_far, r3_s54;
    logic [SIG_W-1:0] r3_q, r3_rem, r3_half;
    logic [10:0]      r3_e;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_kind <= r2_kind;
            r3_x    <= r2_x;
            r3_ovf  <= ovf3;
            r3_nrm  <= nrm3;
            r3_far  <= far3;
            r3_s54  <= (sh == 6'd54);
            r3_q    <= nrm3 ? r2_sig : q3;
            r3_rem  <= rem3;
            r3_half <= half3;
            r3_e    <= r2_exp[10:0];
        end
    end

    // ---------------- stage 4: round and assemble
    logic        up4;
    logic [63:0] n4_res;
    logic [3:0]  n4_flg;   // invalid, overflow, underflow, inexact

    always_comb begin
        if (r3_s54) begin
            // rem is the full significand, half is 2^53: never above or equal
            up4 = 1'b0;
        end else begin
            up4 = (r3_rem > r3_half) || (r3_rem == r3_half && r3_q[0]);
        end
        n4_res = r3_x;
        n4_flg = '0;
        unique case (r3_kind)
            K_QUIET: begin
                n4_res = r3_x | QUIET_BIT;
                n4_flg = 4'b1000;
            end
            K_PASS: begin
                n4_res = r3_x;
            end
            default: begin
                if (r3_ovf) begin
                    n4_res = (r3_x & SIGN_MASK) | INF_BITS;
                    n4_flg = 4'b0101;
                end else if (r3_nrm) begin
                    n4_res = {r3_x[63], r3_e, r3_q[51:0]};
                end else if (r3_far) begin
                    n4_res = r3_x & SIGN_MASK;
                    n4_flg = 4'b0011;
                end else begin
                    n4_res = {r3_x[63], 63'(r3_q + SIG_W'(up4))};
                    n4_flg = (r3_rem != '0) ? 4'b0011 : 4'b0000;
                end
            end
        endcase
    end

    logic [63:0] r4_res;
    logic [3:0]  r4_flg;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_res <= n4_res;
            r4_flg <= n4_flg;
        end
    end

    assign o_valid          = r_vld[3];
    assign o_result_bits    = r4_res;
    assign o_flag_invalid   = r4_flg[3];
    assign o_flag_overflow  = r4_flg[2];
    assign o_flag_underflow = r4_flg[1];
    assign o_flag_inexact   = r4_flg[0];

    `ASSERT_CLK(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(r4_res))
    `ASSERT_CLK(a_ready_full, i_clk, i_rst_n, !o_ready |-> r_vld == 4'b1111 && !i_ready)
    `ASSERT_CLK(a_ovf_inx, i_clk, i_rst_n, o_valid && o_flag_overflow |-> o_flag_inexact)
    `ASSERT_CLK(a_inv_alone, i_clk, i_rst_n,
        o_valid && o_flag_invalid |-> !o_flag_overflow && !o_flag_underflow)
    `ASSERT_NORST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)
endmodule

### tb/fp64_scale_by_power_of_two_tb.sv
// testbench for the binary64 scale-by-power-of-two pipeline
`timescale 1ns / 1ps

module fp64_scale_by_power_of_two_tb;
    import fp64sc_pkg::*;

    typedef struct {
        logic [63:0] bits;
        logic        invalid;
        logic        overflow;
        logic        underflow;
        logic        inexact;
    } t_scaled;

    class scale_scoreboard;
        t_scaled pending[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // x * 2^n in round to nearest even, with the four exception flags
        function t_scaled scale_double(logic [63:0] x, logic signed [31:0] n);
            t_scaled     r;
            logic [63:0] sgn;
            logic [63:0] mag;
            logic [63:0] sig;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            longint      e;
            longint      sh;
            r = '{x, 1'b0, 1'b0, 1'b0, 1'b0};
            sgn = x & SIGN_MASK;
            mag = x & ~SIGN_MASK;
            if (mag > INF_BITS) begin
                if ((mag & QUIET_BIT) == 0) begin
                    r.bits = x | QUIET_BIT;
                    r.invalid = 1'b1;
                end
                return r;
            end
            if (mag == INF_BITS || mag == 0 || n == 0)
                return r;
            e = longint'(mag[62:52]);
            if (e == 0) begin
                sig = {12'd0, mag[51:0]};
                e = 1;
                while (sig[52] == 1'b0) begin
                    sig = sig << 1;
                    e = e - 1;
                end
            end else begin
                sig = {11'd0, 1'b1, mag[51:0]};
            end
            e = e + longint'(n);
            if (e > 2046) begin
                r = '{sgn | INF_BITS, 1'b0, 1'b1, 1'b0, 1'b1};
            end else if (e >= 1) begin
                r.bits = sgn | (64'(e) << 52) | {12'd0, sig[51:0]};
            end else begin
                sh = 1 - e;
                if (sh > 54) begin
                    r = '{sgn, 1'b0, 1'b0, 1'b1, 1'b1};
                end else begin
                    q = sig >> sh;
                    rem = sig & ((64'd1 << sh) - 64'd1);
                    half = 64'd1 << (sh - 1);
                    if (rem > half || (rem == half && q[0]))
                        q = q + 64'd1;
                    r.bits = sgn | q;
                    r.underflow = (rem != 0);
                    r.inexact = (rem != 0);
                end
            end
            return r;
        endfunction

        function void note_operand(logic [63:0] x, logic signed [31:0] n);
            pending.push_back(scale_double(x, n));
        endfunction

        function void check_result(t_scaled got);
            t_scaled want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got.bits);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.bits !== want.bits) begin
                $display("%0t: result_bits expected %h actual %h", $time, want.bits, got.bits);
                errors++;
            end
            if (got.invalid !== want.invalid) begin
                $display("%0t: invalid expected %b actual %b", $time, want.invalid, got.invalid);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                         got.overflow);
                errors++;
            end
            if (got.underflow !== want.underflow) begin
                $display("%0t: underflow expected %b actual %b", $time, want.underflow,
                         got.underflow);
                errors++;
            end
            if (got.inexact !== want.inexact) begin
                $display("%0t: inexact expected %b actual %b", $time, want.inexact, got.inexact);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [63:0]        i_x_bits = '0;
    logic signed [31:0] i_shift_count = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [63:0]        o_result_bits;
    logic               o_flag_invalid;
    logic               o_flag_overflow;
    logic               o_flag_underflow;
    logic               o_flag_inexact;

    scale_scoreboard sb = new();
    bit              steady = 1'b0;
    int              quiet_cycles = 0;

    fp64_scale_by_power_of_two dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_x_bits(i_x_bits), .i_shift_count(i_shift_count),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_bits(o_result_bits),
        .o_flag_invalid(o_flag_invalid), .o_flag_overflow(o_flag_overflow),
        .o_flag_underflow(o_flag_underflow), .o_flag_inexact(o_flag_inexact)
    );

    always #6 i_clk = ~i_clk;

    // sink back-pressure
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 20);
    end

    // beats taken at the rising edge, before any register updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_operand(i_x_bits, i_shift_count);
            if (o_valid && i_ready)
                sb.check_result('{o_result_bits, o_flag_invalid, o_flag_overflow,
                                  o_flag_underflow, o_flag_inexact});
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_operand(input logic [63:0] x, input logic signed [31:0] n);
        while (!steady && $urandom_range(99) < 20) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_x_bits <= x;
        i_shift_count <= n;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(9))
            0: x[62:52] = 11'd0;                               // subnormal or zero
            1: x[62:52] = 11'h7ff;                             // nan or infinity
            2: x[51:0] = ($urandom_range(1)) ? 52'd0 : 52'd1;
            3: x[62:52] = 11'($urandom_range(1, 60));
            4: x[62:52] = 11'($urandom_range(1990, 2046));
            5: begin
                x[62:52] = 11'd0;
                x[51:0] = x[51:0] >> $urandom_range(51);       // deep subnormal
            end
            default: ;
        endcase
        return x;
    endfunction

    function automatic logic signed [31:0] random_count();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'sd2100 - 32'($urandom_range(4200));
            2: return -32'sd1022 - 32'($urandom_range(60));
            3: return 32'($urandom_range(1, 4)) << $urandom_range(27, 30);
            default: return 32'sd60 - 32'($urandom_range(120));
        endcase
    endfunction

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_operand(64'h0000_0000_0000_0000, 32'sd5);
        send_operand(64'h8000_0000_0000_0000, -32'sd5);
        send_operand(64'h7ff0_0000_0000_0000, -32'sd3000);
        send_operand(64'hfff0_0000_0000_0000, 32'sd1);
        send_operand(64'h7ff8_0000_0000_0001, 32'sd7);           // quiet nan
        send_operand(64'h7ff0_0000_0000_0001, 32'sd7);           // signalling nan
        send_operand(64'hfff7_ffff_ffff_ffff, 32'sd0);
        send_operand(64'h3ff0_0000_0000_0000, 32'sd0);           // zero count
        send_operand(64'h3ff0_0000_0000_0000, 32'h7fff_ffff);
        send_operand(64'hbff0_0000_0000_0000, 32'h8000_0000);
        send_operand(64'h7fef_ffff_ffff_ffff, 32'sd1);           // just overflows
        send_operand(64'h0000_0000_0000_0001, 32'sd1074);        // min subnormal up
        send_operand(64'h0000_0000_0000_0001, 32'h7fff_ffff);
        send_operand(64'h8000_0000_0000_0001, -32'sd1);          // tie to even, to zero
        send_operand(64'h0000_0000_0000_0003, -32'sd1);          // tie rounds up
        send_operand(64'h001f_ffff_ffff_ffff, -32'sd1);          // rounds into normal
        send_operand(64'h0010_0000_0000_0000, -32'sd52);
        send_operand(64'h0010_0000_0000_0000, -32'sd53);         // exactly half ulp
        send_operand(64'h0018_0000_0000_0000, -32'sd53);
        send_operand(64'h3ff0_0000_0000_0000, -32'sd1076);       // below half the smallest subnormal
        send_operand(64'h000f_ffff_ffff_ffff, 32'sd1);           // subnormal to normal
        send_operand(64'h000f_ffff_ffff_ffff, -32'sd3);
        send_operand(64'h7fef_ffff_ffff_ffff, -32'sd2098);

        for (k = 0; k < 1600; k++) begin
            steady = (k >= 700 && k < 900);
            send_operand(random_double(), random_count());
        end
        steady = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
